// ===== sv/scc_pkg.sv =====
`timescale 1ns / 1ps
package scc_pkg;

  typedef logic signed [23:0] coord_t;

  typedef enum logic [2:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_END_X   = 3'd2,
    CFG_END_Y   = 3'd3,
    CFG_LHW     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    logic [15:0] lhw;
  } seg_t;

  typedef struct packed {
    coord_t      px;
    coord_t      py;
    logic [15:0] rad;
    coord_t      spd;
    logic [15:0] el;
  } item_t;

  typedef struct packed {
    item_t              it;
    logic [16:0]        rs;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic               hit;
  } mid_t;

  typedef struct packed {
    coord_t             px;
    coord_t             py;
    coord_t             fs;
    logic               hit;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic               negx;
    logic               negy;
  } pd_side_t;

  typedef struct packed {
    logic   hit;
    coord_t fx;
    coord_t fy;
    coord_t fs;
  } cd_side_t;

  localparam int DIV_T_STEPS = 31;
  localparam int SQRT_STEPS  = 26;
  localparam int PUSH_QBITS  = 20;
  localparam int CORDIC_N    = 17;

  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q13 = 20'sd12868;
  localparam logic signed [19:0] ANG_MIN     = -20'sd38604;
  localparam logic signed [19:0] ANG_MAX     = 20'sd12868;

  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0:    return 16'd51472;
      5'd1:    return 16'd30386;
      5'd2:    return 16'd16055;
      5'd3:    return 16'd8150;
      5'd4:    return 16'd4091;
      5'd5:    return 16'd2047;
      5'd6:    return 16'd1024;
      5'd7:    return 16'd512;
      5'd8:    return 16'd256;
      5'd9:    return 16'd128;
      5'd10:   return 16'd64;
      5'd11:   return 16'd32;
      5'd12:   return 16'd16;
      5'd13:   return 16'd8;
      5'd14:   return 16'd4;
      5'd15:   return 16'd2;
      5'd16:   return 16'd1;
      default: return 16'd0;
    endcase
  endfunction

  function automatic coord_t sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

endpackage

// ===== sv/scc_proj.sv =====
`timescale 1ns / 1ps
module scc_proj (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  scc_pkg::item_t      in_item,
  input  scc_pkg::seg_t       seg,
  output logic                out_valid,
  output logic signed [24:0]  out_dx,
  output logic signed [24:0]  out_dy,
  output scc_pkg::item_t      out_item
);

  typedef struct packed {
    logic [50:0]        r;
    logic [30:0]        t;
    logic [49:0]        e;
    logic               zero;
    logic               full;
    logic signed [24:0] lx;
    logic signed [24:0] ly;
    scc_pkg::item_t     it;
  } dst_t;

  logic                v1, v2, v3;
  logic signed [24:0]  lx1, ly1, qx1, qy1;
  scc_pkg::item_t      it1, it2, it3;
  logic signed [49:0]  plx2, ply2, pdx2, pdy2;
  logic signed [24:0]  lx2, ly2, lx3, ly3;
  logic [49:0]         e3;
  logic signed [50:0]  d3;
  logic [49:0]         dcl;

  logic                dv [0:scc_pkg::DIV_T_STEPS];
  dst_t                ds [0:scc_pkg::DIV_T_STEPS];
  dst_t                dnx [1:scc_pkg::DIV_T_STEPS];

  logic [31:0]         tq;
  logic                vt, vr;
  logic signed [57:0]  pmx, pmy;
  scc_pkg::item_t      itt, itr;
  logic [57:0]         magx, magy, sumx, sumy;
  logic [26:0]         qrx, qry;
  logic signed [26:0]  offx, offy;
  logic signed [27:0]  dxw, dyw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vt <= 1'b0;
      vr <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= scc_pkg::DIV_T_STEPS; k++) begin
        dv[k] <= 1'b0;
      end
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      dv[0] <= v3;
      for (int k = 0; k < scc_pkg::DIV_T_STEPS; k++) begin
        dv[k+1] <= dv[k];
      end
      vt <= dv[scc_pkg::DIV_T_STEPS];
      vr <= vt;
      out_valid <= vr;
    end
  end

  always_comb begin
    if (d3 < 0) begin
      dcl = '0;
    end else if (d3 > $signed({1'b0, e3})) begin
      dcl = e3;
    end else begin
      dcl = d3[49:0];
    end
  end

  always_comb begin
    for (int k = 0; k < scc_pkg::DIV_T_STEPS; k++) begin
      dnx[k+1]   = ds[k];
      dnx[k+1].r = {ds[k].r[49:0], 1'b0};
      dnx[k+1].t = {ds[k].t[29:0], 1'b0};
      if (dnx[k+1].r >= {1'b0, ds[k].e}) begin
        dnx[k+1].r    = dnx[k+1].r - {1'b0, ds[k].e};
        dnx[k+1].t[0] = 1'b1;
      end
    end
  end

  always_comb begin
    if (ds[scc_pkg::DIV_T_STEPS].zero) begin
      tq = '0;
    end else if (ds[scc_pkg::DIV_T_STEPS].full) begin
      tq = 32'h8000_0000;
    end else begin
      tq = {1'b0, ds[scc_pkg::DIV_T_STEPS].t};
    end
  end

  always_comb begin
    magx = pmx[57] ? 58'(-pmx) : 58'(pmx);
    magy = pmy[57] ? 58'(-pmy) : 58'(pmy);
    sumx = magx + 58'h4000_0000;
    sumy = magy + 58'h4000_0000;
    qrx  = sumx[57:31];
    qry  = sumy[57:31];
    dxw  = {{4{seg.sx[23]}}, seg.sx} + {offx[26], offx}
           - {{4{itr.px[23]}}, itr.px};
    dyw  = {{4{seg.sy[23]}}, seg.sy} + {offy[26], offy}
           - {{4{itr.py[23]}}, itr.py};
  end

  always_ff @(posedge clk) begin
    lx1  <= {seg.ex[23], seg.ex} - {seg.sx[23], seg.sx};
    ly1  <= {seg.ey[23], seg.ey} - {seg.sy[23], seg.sy};
    qx1  <= {in_item.px[23], in_item.px} - {seg.sx[23], seg.sx};
    qy1  <= {in_item.py[23], in_item.py} - {seg.sy[23], seg.sy};
    it1  <= in_item;

    plx2 <= lx1 * lx1;
    ply2 <= ly1 * ly1;
    pdx2 <= lx1 * qx1;
    pdy2 <= ly1 * qy1;
    lx2  <= lx1;
    ly2  <= ly1;
    it2  <= it1;

    e3   <= plx2[49:0] + ply2[49:0];
    d3   <= 51'(pdx2) + 51'(pdy2);
    lx3  <= lx2;
    ly3  <= ly2;
    it3  <= it2;

    ds[0].r    <= {1'b0, dcl};
    ds[0].t    <= '0;
    ds[0].e    <= e3;
    ds[0].zero <= (e3 == '0);
    ds[0].full <= (dcl == e3);
    ds[0].lx   <= lx3;
    ds[0].ly   <= ly3;
    ds[0].it   <= it3;
    for (int k = 1; k <= scc_pkg::DIV_T_STEPS; k++) begin
      ds[k] <= dnx[k];
    end

    pmx  <= $signed({1'b0, tq}) * ds[scc_pkg::DIV_T_STEPS].lx;
    pmy  <= $signed({1'b0, tq}) * ds[scc_pkg::DIV_T_STEPS].ly;
    itt  <= ds[scc_pkg::DIV_T_STEPS].it;

    offx <= pmx[57] ? -$signed(qrx) : $signed(qrx);
    offy <= pmy[57] ? -$signed(qry) : $signed(qry);
    itr  <= itt;

    out_dx   <= dxw[24:0];
    out_dy   <= dyw[24:0];
    out_item <= itr;
  end

endmodule

// ===== sv/scc_sqrt.sv =====
`timescale 1ns / 1ps
module scc_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [34:0]   in_d2,
  input  scc_pkg::mid_t in_side,
  output logic          out_valid,
  output logic [25:0]   out_root,
  output scc_pkg::mid_t out_side
);

  typedef struct packed {
    logic [51:0]   rad;
    logic [28:0]   rem;
    logic [25:0]   root;
    scc_pkg::mid_t sd;
  } sst_t;

  logic        sv [0:scc_pkg::SQRT_STEPS];
  sst_t        st [0:scc_pkg::SQRT_STEPS];
  sst_t        sn [1:scc_pkg::SQRT_STEPS];
  logic [28:0] rem2;
  logic [28:0] trial;

  always_comb begin
    rem2  = '0;
    trial = '0;
    for (int k = 0; k < scc_pkg::SQRT_STEPS; k++) begin
      sn[k+1]     = st[k];
      rem2        = {st[k].rem[26:0], st[k].rad[51:50]};
      trial       = {1'b0, st[k].root, 2'b01};
      sn[k+1].rad = {st[k].rad[49:0], 2'b00};
      if (rem2 >= trial) begin
        sn[k+1].rem  = rem2 - trial;
        sn[k+1].root = {st[k].root[24:0], 1'b1};
      end else begin
        sn[k+1].rem  = rem2;
        sn[k+1].root = {st[k].root[24:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= scc_pkg::SQRT_STEPS; k++) begin
        sv[k] <= 1'b0;
      end
    end else begin
      sv[0] <= in_valid;
      for (int k = 0; k < scc_pkg::SQRT_STEPS; k++) begin
        sv[k+1] <= sv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    st[0].rad  <= {1'b0, in_d2, 16'h0000};
    st[0].rem  <= '0;
    st[0].root <= '0;
    st[0].sd   <= in_side;
    for (int k = 1; k <= scc_pkg::SQRT_STEPS; k++) begin
      st[k] <= sn[k];
    end
  end

  assign out_valid = sv[scc_pkg::SQRT_STEPS];
  assign out_root  = st[scc_pkg::SQRT_STEPS].root;
  assign out_side  = st[scc_pkg::SQRT_STEPS].sd;

endmodule

// ===== sv/scc_pdiv.sv =====
`timescale 1ns / 1ps
module scc_pdiv (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [43:0]       in_nx,
  input  logic [43:0]       in_ny,
  input  logic [25:0]       in_den,
  input  scc_pkg::pd_side_t in_side,
  output logic              out_valid,
  output logic [19:0]       out_qx,
  output logic [19:0]       out_qy,
  output scc_pkg::pd_side_t out_side
);

  typedef struct packed {
    logic [26:0]       rx;
    logic [26:0]       ry;
    logic [19:0]       lx;
    logic [19:0]       ly;
    logic [19:0]       qx;
    logic [19:0]       qy;
    logic [25:0]       den;
    scc_pkg::pd_side_t sd;
  } pst_t;

  logic pv [0:scc_pkg::PUSH_QBITS];
  pst_t st [0:scc_pkg::PUSH_QBITS];
  pst_t sn [1:scc_pkg::PUSH_QBITS];

  always_comb begin
    for (int k = 0; k < scc_pkg::PUSH_QBITS; k++) begin
      sn[k+1]    = st[k];
      sn[k+1].rx = {st[k].rx[25:0], st[k].lx[19]};
      sn[k+1].ry = {st[k].ry[25:0], st[k].ly[19]};
      sn[k+1].lx = {st[k].lx[18:0], 1'b0};
      sn[k+1].ly = {st[k].ly[18:0], 1'b0};
      sn[k+1].qx = {st[k].qx[18:0], 1'b0};
      sn[k+1].qy = {st[k].qy[18:0], 1'b0};
      if (sn[k+1].rx >= {1'b0, st[k].den}) begin
        sn[k+1].rx    = sn[k+1].rx - {1'b0, st[k].den};
        sn[k+1].qx[0] = 1'b1;
      end
      if (sn[k+1].ry >= {1'b0, st[k].den}) begin
        sn[k+1].ry    = sn[k+1].ry - {1'b0, st[k].den};
        sn[k+1].qy[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= scc_pkg::PUSH_QBITS; k++) begin
        pv[k] <= 1'b0;
      end
    end else begin
      pv[0] <= in_valid;
      for (int k = 0; k < scc_pkg::PUSH_QBITS; k++) begin
        pv[k+1] <= pv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    st[0].rx  <= {3'b000, in_nx[43:20]};
    st[0].ry  <= {3'b000, in_ny[43:20]};
    st[0].lx  <= in_nx[19:0];
    st[0].ly  <= in_ny[19:0];
    st[0].qx  <= '0;
    st[0].qy  <= '0;
    st[0].den <= in_den;
    st[0].sd  <= in_side;
    for (int k = 1; k <= scc_pkg::PUSH_QBITS; k++) begin
      st[k] <= sn[k];
    end
  end

  assign out_valid = pv[scc_pkg::PUSH_QBITS];
  assign out_qx    = st[scc_pkg::PUSH_QBITS].qx;
  assign out_qy    = st[scc_pkg::PUSH_QBITS].qy;
  assign out_side  = st[scc_pkg::PUSH_QBITS].sd;

endmodule

// ===== sv/scc_cordic.sv =====
`timescale 1ns / 1ps
module scc_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [17:0] in_x,
  input  logic signed [17:0] in_y,
  input  scc_pkg::cd_side_t  in_side,
  output logic               out_valid,
  output logic signed [16:0] out_angle,
  output scc_pkg::cd_side_t  out_side
);

  typedef struct packed {
    logic signed [40:0] x;
    logic signed [40:0] y;
    logic signed [19:0] z;
    logic               zero;
    scc_pkg::cd_side_t  sd;
  } cst_t;

  logic               cv [0:scc_pkg::CORDIC_N];
  cst_t               st [0:scc_pkg::CORDIC_N];
  cst_t               sn [1:scc_pkg::CORDIC_N];
  logic signed [40:0] xi, yi, x0, y0, xsh, ysh;
  logic signed [19:0] z0, zc, ang, ang2, angc;
  logic [19:0]        mz;
  logic [16:0]        qa;
  logic [19:0]        qsum;

  always_comb begin
    xi = {{3{in_x[17]}}, in_x, 20'h00000};
    yi = {{3{in_y[17]}}, in_y, 20'h00000};
    x0 = xi;
    y0 = yi;
    z0 = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        x0 = yi;
        y0 = -xi;
        z0 = scc_pkg::HALF_PI_Q16;
      end else begin
        x0 = -yi;
        y0 = xi;
        z0 = -scc_pkg::HALF_PI_Q16;
      end
    end
  end

  always_comb begin
    xsh = '0;
    ysh = '0;
    for (int k = 0; k < scc_pkg::CORDIC_N; k++) begin
      sn[k+1] = st[k];
      xsh     = st[k].x >>> k;
      ysh     = st[k].y >>> k;
      if (st[k].y > 0) begin
        sn[k+1].x = st[k].x + ysh;
        sn[k+1].y = st[k].y - xsh;
        sn[k+1].z = st[k].z + $signed({4'h0, scc_pkg::atan_q16(5'(k))});
      end else begin
        sn[k+1].x = st[k].x - ysh;
        sn[k+1].y = st[k].y + xsh;
        sn[k+1].z = st[k].z - $signed({4'h0, scc_pkg::atan_q16(5'(k))});
      end
    end
  end

  always_comb begin
    if (st[scc_pkg::CORDIC_N].zero) begin
      zc = '0;
    end else if (st[scc_pkg::CORDIC_N].z > scc_pkg::PI_Q16) begin
      zc = scc_pkg::PI_Q16;
    end else if (st[scc_pkg::CORDIC_N].z < -scc_pkg::PI_Q16) begin
      zc = -scc_pkg::PI_Q16;
    end else begin
      zc = st[scc_pkg::CORDIC_N].z;
    end
    mz   = zc[19] ? 20'(-zc) : 20'(zc);
    qsum = mz + 20'd4;
    qa   = qsum[19:3];
    ang  = zc[19] ? -$signed({3'b000, qa}) : $signed({3'b000, qa});
    ang2 = ang - scc_pkg::HALF_PI_Q13;
    if (ang2 < scc_pkg::ANG_MIN) begin
      angc = scc_pkg::ANG_MIN;
    end else if (ang2 > scc_pkg::ANG_MAX) begin
      angc = scc_pkg::ANG_MAX;
    end else begin
      angc = ang2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= scc_pkg::CORDIC_N; k++) begin
        cv[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      cv[0] <= in_valid;
      for (int k = 0; k < scc_pkg::CORDIC_N; k++) begin
        cv[k+1] <= cv[k];
      end
      out_valid <= cv[scc_pkg::CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    st[0].x    <= x0;
    st[0].y    <= y0;
    st[0].z    <= z0;
    st[0].zero <= (in_x == '0) && (in_y == '0);
    st[0].sd   <= in_side;
    for (int k = 1; k <= scc_pkg::CORDIC_N; k++) begin
      st[k] <= sn[k];
    end
    out_angle <= angc[16:0];
    out_side  <= st[scc_pkg::CORDIC_N].sd;
  end

endmodule

// ===== sv/segment_circle_collide.sv =====
`timescale 1ns / 1ps
// Channel   Signals                                        Transfer when
// --------  ---------------------------------------------  -----------------------
// item in   start, pos_x, pos_y, radius, speed_in,         start && !busy
//           elasticity
// result    done, hit, new_x, new_y, new_speed, new_angle  done (one cycle)
// config    cfg_valid, cfg_index, cfg_data, cfg_ready      cfg_valid && cfg_ready
//
// One item enters per cycle; busy stays low. Each result passes through a pipeline
// of 113 register stages, from the start transfer to done. The depth is set by
// the bit-per-stage projection divider (31), square root (26), push divider (20)
// and CORDIC (17). Synchronous reset clears valid bits and configuration;
// results cannot stall.
module segment_circle_collide (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [15:0]        radius,
  input  logic signed [23:0] speed_in,
  input  logic [15:0]        elasticity,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               done,
  output logic               hit,
  output logic signed [23:0] new_x,
  output logic signed [23:0] new_y,
  output logic signed [23:0] new_speed,
  output logic signed [16:0] new_angle
);

  scc_pkg::seg_t      seg;
  scc_pkg::item_t     in_item;

  logic               p_valid;
  logic signed [24:0] p_dx, p_dy;
  scc_pkg::item_t     p_item;

  logic [16:0]        rs_c;
  logic [24:0]        adx_c, ady_c;

  logic               v1, v2, v3;
  scc_pkg::item_t     it1, it2;
  logic [16:0]        rs1, rs2;
  logic [16:0]        adx1, ady1;
  logic signed [17:0] dx1, dy1, dx2, dy2;
  logic               pre1, pre2;
  logic [33:0]        sqx2, sqy2, rsq2;
  logic [34:0]        d2_c;
  logic [34:0]        d2_3;
  scc_pkg::mid_t      mid3;

  logic               s_valid;
  logic [25:0]        s_root;
  scc_pkg::mid_t      s_side;
  logic [17:0]        rsp_c;
  logic [17:0]        sadx_c, sady_c;

  logic               v4, v5, v6;
  logic [25:0]        ov4, den4, den5;
  logic               z04, z05;
  logic [16:0]        adx4, ady4;
  logic signed [40:0] prod4;
  scc_pkg::pd_side_t  pd4, pd5, pd6;
  scc_pkg::pd_side_t  pd5_c;
  logic [42:0]        mx5, my5;
  logic [40:0]        pmag_c, psum_c;
  logic [25:0]        pq_c;
  logic signed [26:0] pns_c;
  scc_pkg::coord_t    ns_c;
  logic [43:0]        nxn6, nyn6;
  logic [25:0]        den6;

  logic               d_valid;
  logic [19:0]        d_qx, d_qy;
  scc_pkg::pd_side_t  d_side;
  logic signed [20:0] pushx_c, pushy_c;
  logic signed [26:0] nxw_c, nyw_c;

  logic               v7;
  logic signed [17:0] cx7, cy7;
  scc_pkg::cd_side_t  cd7;

  logic               c_valid;
  logic signed [16:0] c_angle;
  scc_pkg::cd_side_t  c_side;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (scc_pkg::cfg_idx_t'(cfg_index))
        scc_pkg::CFG_START_X: seg.sx <= cfg_data;
        scc_pkg::CFG_START_Y: seg.sy <= cfg_data;
        scc_pkg::CFG_END_X:   seg.ex <= cfg_data;
        scc_pkg::CFG_END_Y:   seg.ey <= cfg_data;
        scc_pkg::CFG_LHW:     seg.lhw <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.px  = pos_x;
    in_item.py  = pos_y;
    in_item.rad = radius;
    in_item.spd = speed_in;
    in_item.el  = elasticity;
  end

  scc_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_item   (in_item),
    .seg       (seg),
    .out_valid (p_valid),
    .out_dx    (p_dx),
    .out_dy    (p_dy),
    .out_item  (p_item)
  );

  always_comb begin
    rs_c  = 17'(p_item.rad) + 17'(seg.lhw);
    adx_c = p_dx[24] ? 25'(-p_dx) : 25'(p_dx);
    ady_c = p_dy[24] ? 25'(-p_dy) : 25'(p_dy);
    d2_c  = 35'(sqx2) + 35'(sqy2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= p_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= s_valid;
      v5 <= v4;
      v6 <= v5;
      v7 <= d_valid;
      done <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    it1  <= p_item;
    rs1  <= rs_c;
    adx1 <= adx_c[16:0];
    ady1 <= ady_c[16:0];
    dx1  <= p_dx[17:0];
    dy1  <= p_dy[17:0];
    pre1 <= (adx_c < 25'(rs_c)) && (ady_c < 25'(rs_c));

    sqx2 <= 34'(adx1) * 34'(adx1);
    sqy2 <= 34'(ady1) * 34'(ady1);
    rsq2 <= 34'(rs1) * 34'(rs1);
    it2  <= it1;
    rs2  <= rs1;
    dx2  <= dx1;
    dy2  <= dy1;
    pre2 <= pre1;

    d2_3     <= d2_c;
    mid3.it  <= it2;
    mid3.rs  <= rs2;
    mid3.dx  <= dx2;
    mid3.dy  <= dy2;
    mid3.hit <= pre2 && (d2_c <= 35'(rsq2));
  end

  scc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_d2     (d2_3),
    .in_side   (mid3),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  always_comb begin
    rsp_c  = 18'(s_side.rs) + 18'd256;
    sadx_c = s_side.dx[17] ? 18'(-s_side.dx) : 18'(s_side.dx);
    sady_c = s_side.dy[17] ? 18'(-s_side.dy) : 18'(s_side.dy);
    pmag_c = prod4[40] ? 41'(-prod4) : 41'(prod4);
    psum_c = pmag_c + 41'd16384;
    pq_c   = psum_c[40:15];
    pns_c  = prod4[40] ? -$signed({1'b0, pq_c}) : $signed({1'b0, pq_c});
    ns_c   = scc_pkg::sat24(pns_c);
    pd5_c    = pd4;
    pd5_c.fs = pd4.hit ? ns_c : pd4.fs;
  end

  always_ff @(posedge clk) begin
    ov4      <= {rsp_c, 8'h00} - s_root;
    z04      <= (s_root == '0);
    den4     <= (s_root == '0) ? 26'd256 : s_root;
    adx4     <= sadx_c[16:0];
    ady4     <= sady_c[16:0];
    prod4    <= s_side.it.spd * $signed({1'b0, s_side.it.el});
    pd4.px   <= s_side.it.px;
    pd4.py   <= s_side.it.py;
    pd4.fs   <= s_side.it.spd;
    pd4.hit  <= s_side.hit;
    pd4.dx   <= s_side.dx;
    pd4.dy   <= s_side.dy;
    pd4.negx <= (s_root != '0) && s_side.dx[17];
    pd4.negy <= (s_root != '0) && s_side.dy[17];

    mx5    <= z04 ? 43'(ov4) : 43'(ov4) * 43'(adx4);
    my5    <= z04 ? 43'd0 : 43'(ov4) * 43'(ady4);
    z05    <= z04;
    den5   <= den4;
    pd5    <= pd5_c;

    nxn6 <= 44'(mx5) + 44'(den5[25:1]);
    nyn6 <= 44'(my5) + (z05 ? 44'd0 : 44'(den5[25:1]));
    den6 <= den5;
    pd6  <= pd5;
  end

  scc_pdiv u_pdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_nx     (nxn6),
    .in_ny     (nyn6),
    .in_den    (den6),
    .in_side   (pd6),
    .out_valid (d_valid),
    .out_qx    (d_qx),
    .out_qy    (d_qy),
    .out_side  (d_side)
  );

  always_comb begin
    pushx_c = d_side.negx ? -$signed({1'b0, d_qx}) : $signed({1'b0, d_qx});
    pushy_c = d_side.negy ? -$signed({1'b0, d_qy}) : $signed({1'b0, d_qy});
    nxw_c   = {{3{d_side.px[23]}}, d_side.px} - {{6{pushx_c[20]}}, pushx_c};
    nyw_c   = {{3{d_side.py[23]}}, d_side.py} - {{6{pushy_c[20]}}, pushy_c};
  end

  always_ff @(posedge clk) begin
    cx7     <= d_side.dx;
    cy7     <= d_side.dy;
    cd7.hit <= d_side.hit;
    cd7.fx  <= d_side.hit ? scc_pkg::sat24(nxw_c) : d_side.px;
    cd7.fy  <= d_side.hit ? scc_pkg::sat24(nyw_c) : d_side.py;
    cd7.fs  <= d_side.fs;
  end

  scc_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .in_x      (cx7),
    .in_y      (cy7),
    .in_side   (cd7),
    .out_valid (c_valid),
    .out_angle (c_angle),
    .out_side  (c_side)
  );

  always_ff @(posedge clk) begin
    hit       <= c_side.hit;
    new_x     <= c_side.fx;
    new_y     <= c_side.fy;
    new_speed <= c_side.fs;
    new_angle <= c_side.hit ? c_angle : 17'sd0;
  end

endmodule
